// ===== src/ilha_pkg.sv =====
// ----------------------------------------------------------------------------
// ilha_pkg
// Shared types and constants of the implicit-list heap allocator: request
// field widths, opcodes, status codes and granule geometry.
// ----------------------------------------------------------------------------
package ilha_pkg;

  // Default heap capacity in 16-byte granules
  localparam int HeapGranulesDef = 4096;

  // Request / response field widths
  localparam int OpcodeW = 1;
  localparam int BytesW  = 16;
  localparam int AddrW   = 17;
  localparam int StatusW = 2;
  localparam int NeedW   = 13;  // granules for the largest request

  // Heap geometry
  localparam int GranuleBytes = 16;
  localparam int GranShift    = 4;
  localparam int HdrBytes     = 8;

  // Opcodes
  localparam logic [OpcodeW-1:0] OP_ALLOC = 1'b0;
  localparam logic [OpcodeW-1:0] OP_FREE  = 1'b1;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_OOM     = 2'd1;
  localparam logic [StatusW-1:0] ST_IGNORED = 2'd2;

endpackage

// ===== src/ilha_ram.sv =====
// ----------------------------------------------------------------------------
// ilha_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ilha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/implicit_list_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator
// First-fit allocator over an implicit list of block headers kept in a RAM,
// one header per block start (size in granules and an allocated bit).
// ----------------------------------------------------------------------------
//   channel  | direction | handshake              | payload
//   request  | in        | in_valid_i / in_stall_o   | opcode, request_bytes,
//            |           |                        | payload_address
//   response | out       | out_valid_o / out_stall_i | result_address, status
//
// One request at a time; a single header read port walks the block list.
// Free: walks the block list up to the freed block, then clears its bit.
// Alloc: a merge pass over runs of free blocks, then a first-fit pass
// that splits or takes a block, or appends at the heap end.
// The header RAM needs no clearing after reset: only block starts are read.
// A stalled response holds; the next request is taken while it waits.
module implicit_list_heap_allocator
  import ilha_pkg::*;
#(
  parameter int HEAP_GRANULES = ilha_pkg::HeapGranulesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ilha_pkg::OpcodeW-1:0] opcode_i,
  input  logic [ilha_pkg::BytesW-1:0]  request_bytes_i,
  input  logic [ilha_pkg::AddrW-1:0]   payload_address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ilha_pkg::AddrW-1:0]   result_address_o,
  output logic [ilha_pkg::StatusW-1:0] status_o
);
  import ilha_pkg::*;

  // widths: granule index, block size / heap end, header, compare, address
  localparam int AW = $clog2(HEAP_GRANULES);
  localparam int SW = AW + 1;
  localparam int HW = SW + 1;
  localparam int CW = ((SW > NeedW) ? SW : NeedW) + 1;
  localparam int RW = ((SW + GranShift + 1) > AddrW) ? (SW + GranShift + 1) : AddrW;
  localparam int GW = AddrW - GranShift;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FR_CHK = 4'd1;
  localparam logic [3:0] S_FR_DAT = 4'd2;
  localparam logic [3:0] S_MG_CHK = 4'd3;
  localparam logic [3:0] S_MG_CUR = 4'd4;
  localparam logic [3:0] S_MG_NXT = 4'd5;
  localparam logic [3:0] S_SR_CHK = 4'd6;
  localparam logic [3:0] S_SR_DAT = 4'd7;
  localparam logic [3:0] S_SPLIT  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [NeedW-1:0]   need_q, need_d;
  logic [GW-1:0]      g_q, g_d;
  logic [SW-1:0]      cur_q, cur_d;
  logic [SW-1:0]      nxt_q, nxt_d;
  logic [SW-1:0]      cur_sz_q, cur_sz_d;
  logic [SW-1:0]      split_sz_q, split_sz_d;
  logic [SW-1:0]      heap_end_q, heap_end_d;
  logic [AW-1:0]      last_q, last_d;
  logic [AddrW-1:0]   res_q, res_d;
  logic [StatusW-1:0] sts_q, sts_d;
  logic               out_valid_q, out_valid_d;
  logic [AddrW-1:0]   out_addr_q, out_addr_d;
  logic [StatusW-1:0] out_sts_q, out_sts_d;

  // header RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [HW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [HW-1:0] ram_rdata;

  logic [SW-1:0]      rd_sz;
  logic               rd_used;
  logic [AddrW-1:0]   addr_m16;
  logic [AddrW-1:0]   need_sum;
  logic [RW-1:0]      res_cur_w;
  logic [RW-1:0]      res_end_w;
  logic [CW-1:0]      cur_c, end_c, last_c, g_c, need_c, rd_sz_c;

  ilha_ram #(
    .Width (HW),
    .Depth (HEAP_GRANULES)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // header decode and common widened operands
  assign rd_sz   = ram_rdata[HW-1:1];
  assign rd_used = ram_rdata[0];
  assign cur_c   = CW'(cur_q);
  assign end_c   = CW'(heap_end_q);
  assign last_c  = CW'(last_q);
  assign g_c     = CW'(g_q);
  assign need_c  = CW'(need_q);
  assign rd_sz_c = CW'(rd_sz);

  // payload offsets of the current block and of the heap end
  assign res_cur_w = (RW'(cur_q) << GranShift) + RW'(GranuleBytes);
  assign res_end_w = (RW'(heap_end_q) << GranShift) + RW'(GranuleBytes);

  // request decode: granule of a freed payload, granules for an alloc
  assign addr_m16 = payload_address_i - AddrW'(GranuleBytes);
  assign need_sum = AddrW'(request_bytes_i) + AddrW'(HdrBytes + GranuleBytes - 1);

  assign in_stall_o = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    need_d     = need_q;
    g_d        = g_q;
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    cur_sz_d   = cur_sz_q;
    split_sz_d = split_sz_q;
    heap_end_d = heap_end_q;
    last_d     = last_q;
    res_d      = res_q;
    sts_d      = sts_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_sts_d   = out_sts_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_q[AW-1:0];
    ram_wdata  = {rd_sz, 1'b0};
    ram_raddr  = cur_q[AW-1:0];

    // response register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          need_d = need_sum[AddrW-1:GranShift];
          g_d    = addr_m16[AddrW-1:GranShift];
          cur_d  = '0;
          res_d  = '0;
          sts_d  = ST_OK;
          if (opcode_i == OP_FREE) begin
            if (payload_address_i < AddrW'(GranuleBytes) ||
                payload_address_i[GranShift-1:0] != '0) begin
              sts_d   = ST_IGNORED;
              state_d = S_DONE;
            end else begin
              state_d = S_FR_CHK;
            end
          end else if (heap_end_q == '0) begin
            state_d = S_SR_CHK;
          end else begin
            state_d = S_MG_CHK;
          end
        end
      end

      // free: walk block starts up to the target granule
      S_FR_CHK: begin
        if (cur_c >= end_c || cur_c > g_c) begin
          sts_d   = ST_IGNORED;
          state_d = S_DONE;
        end else begin
          state_d = S_FR_DAT;
        end
      end

      S_FR_DAT: begin
        if (cur_c == g_c) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_sz, 1'b0};
          state_d   = S_DONE;
        end else begin
          cur_d   = cur_q + rd_sz;
          state_d = S_FR_CHK;
        end
      end

      // merge pass over runs of free blocks
      S_MG_CHK: begin
        if (cur_c == last_c || cur_c >= end_c) begin
          cur_d   = '0;
          state_d = S_SR_CHK;
        end else begin
          state_d = S_MG_CUR;
        end
      end

      S_MG_CUR: begin
        cur_sz_d  = rd_sz;
        nxt_d     = cur_q + rd_sz;
        ram_raddr = AW'(cur_q + rd_sz);
        if (rd_used) begin
          cur_d   = cur_q + rd_sz;
          state_d = S_MG_CHK;
        end else begin
          state_d = S_MG_NXT;
        end
      end

      S_MG_NXT: begin
        if (!rd_used) begin
          ram_we    = 1'b1;
          ram_wdata = {SW'(cur_sz_q + rd_sz), 1'b0};
          if (CW'(nxt_q) == last_c) begin
            last_d = cur_q[AW-1:0];
          end
        end else begin
          cur_d = nxt_q;
        end
        state_d = S_MG_CHK;
      end

      // first-fit pass, or append at the heap end
      S_SR_CHK: begin
        if (cur_c > last_c || cur_c >= end_c) begin
          if (end_c + need_c > CW'(HEAP_GRANULES)) begin
            sts_d = ST_OOM;
            res_d = '0;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = heap_end_q[AW-1:0];
            ram_wdata  = {SW'(need_q), 1'b1};
            last_d     = heap_end_q[AW-1:0];
            heap_end_d = heap_end_q + SW'(need_q);
            res_d      = res_end_w[AddrW-1:0];
          end
          state_d = S_DONE;
        end else begin
          state_d = S_SR_DAT;
        end
      end

      S_SR_DAT: begin
        if (!rd_used && rd_sz_c >= need_c) begin
          res_d  = res_cur_w[AddrW-1:0];
          ram_we = 1'b1;
          if (rd_sz_c >= need_c + CW'(2)) begin
            ram_wdata  = {SW'(need_q), 1'b1};
            split_sz_d = rd_sz - SW'(need_q);
            nxt_d      = cur_q + SW'(need_q);
            if (cur_c == last_c) begin
              last_d = AW'(cur_q + SW'(need_q));
            end
            state_d = S_SPLIT;
          end else begin
            ram_wdata = {rd_sz, 1'b1};
            state_d   = S_DONE;
          end
        end else begin
          cur_d   = cur_q + rd_sz;
          state_d = S_SR_CHK;
        end
      end

      // free tail of a split block
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = nxt_q[AW-1:0];
        ram_wdata = {split_sz_q, 1'b0};
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_q;
          out_sts_d   = sts_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_end_q  <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_end_q  <= heap_end_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    need_q     <= need_d;
    g_q        <= g_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    cur_sz_q   <= cur_sz_d;
    split_sz_q <= split_sz_d;
    res_q      <= res_d;
    sts_q      <= sts_d;
    out_addr_q <= out_addr_d;
    out_sts_q  <= out_sts_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_sts_q;

endmodule

// ===== src/ilha_checker.sv =====
// ----------------------------------------------------------------------------
// ilha_checker
// Port-level checks of the heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ilha_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ilha_pkg::AddrW-1:0]   result_address_o,
  input logic [ilha_pkg::StatusW-1:0] status_o
);
  import ilha_pkg::*;

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_address_o)
      && $stable(status_o))
    else $error("stalled response changed");

  // one request in flight: an accepted request closes the input
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // status stays within its codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_OOM ||
                     status_o == ST_IGNORED))
    else $error("bad status code");

  // failures and ignored frees carry a null address
  a_null_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OOM || status_o == ST_IGNORED)
      |-> result_address_o == '0)
    else $error("non-null address on failure");

  // payload addresses sit on granule boundaries
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_address_o[GranShift-1:0] == '0)
    else $error("misaligned payload address");

endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the implicit-list heap allocator. A directed table
// hits the edge cases first: null and malformed frees, double free, the
// oversized request, merge of free neighbors, split versus whole-block hand
// out and append. Random traffic follows. A shadow heap predicts every
// response, and the responses are checked field by field in order. Sender
// gaps and receiver stalls vary by phase, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import ilha_pkg::*;

  localparam int HeapGranules   = HeapGranulesDef;
  localparam int RandomPerPhase = 19;
  localparam int HoldOffCycles  = 300;
  localparam int DrainCycles    = 100;
  localparam int TimeoutNs      = 200_000_000;

  typedef struct packed {
    int unsigned size;
    logic        used;
  } hdr_t;

  typedef struct packed {
    logic [AddrW-1:0]   addr;
    logic [StatusW-1:0] status;
  } resp_t;

  // One request of stimulus; fixed_resp marks a hand-typed expected response
  typedef struct {
    logic [OpcodeW-1:0] op;
    logic [BytesW-1:0]  bytes;
    logic [AddrW-1:0]   addr;
    bit                 fixed_resp;
    resp_t              resp;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [OpcodeW-1:0]   opcode_i;
  logic [BytesW-1:0]    request_bytes_i;
  logic [AddrW-1:0]     payload_address_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [AddrW-1:0]     result_address_o;
  logic [StatusW-1:0]   status_o;

  // Shadow heap
  hdr_t                 shadow_hdr [HeapGranules];
  int unsigned          shadow_end;
  int unsigned          shadow_last;

  resp_t                pending_responses [$];
  logic [AddrW-1:0]     live_addrs [$];
  stim_row_t            directed_rows [$];
  int                   fail_cnt       = 0;
  int                   gap_pct        = 0;
  int                   stall_pct      = 0;
  bit                   hold_off_req   = 1'b0;

  implicit_list_heap_allocator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .request_bytes_i   (request_bytes_i),
    .payload_address_i (payload_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_address_o  (result_address_o),
    .status_o          (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one request to the shadow heap and return its response
  function automatic resp_t heap_response(input logic [OpcodeW-1:0] op,
                                          input logic [BytesW-1:0]  bytes,
                                          input logic [AddrW-1:0]   addr);
    resp_t       resp;
    int unsigned need;
    int unsigned cur;
    int unsigned nxt;
    int unsigned g;
    int unsigned bsz;
    bit          hit;
    resp.addr   = '0;
    resp.status = ST_OK;
    if (op == OP_FREE) begin
      if (addr < GranuleBytes || addr[GranShift-1:0] != '0) begin
        resp.status = ST_IGNORED;
      end else begin
        g   = (addr - GranuleBytes) >> GranShift;
        hit = 1'b0;
        cur = 0;
        while (cur < shadow_end && cur <= g) begin
          if (cur == g) hit = 1'b1;
          cur += shadow_hdr[cur].size;
        end
        if (!hit) resp.status = ST_IGNORED;
        else shadow_hdr[g].used = 1'b0;
      end
    end else begin
      need = (bytes + HdrBytes + GranuleBytes - 1) >> GranShift;
      // merge every run of free neighbors
      cur = 0;
      while (shadow_end != 0 && cur != shadow_last && cur < shadow_end) begin
        nxt = cur + shadow_hdr[cur].size;
        if (!shadow_hdr[cur].used && !shadow_hdr[nxt].used) begin
          shadow_hdr[cur].size += shadow_hdr[nxt].size;
          if (nxt == shadow_last) shadow_last = cur;
        end else begin
          cur = nxt;
        end
      end
      // first fit
      hit = 1'b0;
      cur = 0;
      while (!hit && cur <= shadow_last && cur < shadow_end) begin
        if (!shadow_hdr[cur].used && shadow_hdr[cur].size >= need) hit = 1'b1;
        else cur += shadow_hdr[cur].size;
      end
      if (hit) begin
        bsz = shadow_hdr[cur].size;
        if (bsz >= need + 2) begin
          shadow_hdr[cur]        = '{size: need, used: 1'b1};
          shadow_hdr[cur + need] = '{size: bsz - need, used: 1'b0};
          if (cur == shadow_last) shadow_last = cur + need;
        end else begin
          shadow_hdr[cur].used = 1'b1;
        end
        resp.addr = AddrW'(GranuleBytes + GranuleBytes * cur);
      end else if (shadow_end + need > HeapGranules) begin
        resp.status = ST_OOM;
      end else begin
        cur             = shadow_end;
        shadow_hdr[cur] = '{size: need, used: 1'b1};
        shadow_last     = cur;
        shadow_end      = cur + need;
        resp.addr       = AddrW'(GranuleBytes + GranuleBytes * cur);
      end
    end
    return resp;
  endfunction

  function automatic void add_row(input logic [OpcodeW-1:0] op, input int bytes, input int addr,
                                  input bit fixed_resp, input int exp_addr,
                                  input logic [StatusW-1:0] exp_status);
    stim_row_t row;
    row.op          = op;
    row.bytes       = BytesW'(bytes);
    row.addr        = AddrW'(addr);
    row.fixed_resp  = fixed_resp;
    row.resp.addr   = AddrW'(exp_addr);
    row.resp.status = exp_status;
    directed_rows.push_back(row);
  endfunction

  // Mostly frees of live blocks and allocs of small sizes, some noise frees
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    int        idx;
    row.op         = OP_ALLOC;
    row.bytes      = BytesW'($urandom_range(65535));
    row.addr       = AddrW'($urandom_range(65536));
    row.fixed_resp = 1'b0;
    row.resp       = '0;
    pick           = $urandom_range(99);
    if (pick < 40 && live_addrs.size() != 0) begin
      idx     = $urandom_range(live_addrs.size() - 1);
      row.op   = OP_FREE;
      row.addr = live_addrs[idx];
      // some stay listed so they get freed twice later
      if ($urandom_range(99) < 85) live_addrs.delete(idx);
    end else if (pick < 46) begin
      row.op = OP_FREE;
      case ($urandom_range(2))
        0: row.addr = '0;
        1: row.addr = AddrW'($urandom_range(65536));
        default: begin
          row.addr = AddrW'(GranuleBytes + GranuleBytes *
                     $urandom_range(shadow_end == 0 ? 0 : shadow_end - 1));
        end
      endcase
    end else begin
      pick = $urandom_range(99);
      if (pick < 65) row.bytes = BytesW'($urandom_range(255));
      else if (pick < 90) row.bytes = BytesW'($urandom_range(4095, 256));
      else row.bytes = BytesW'($urandom_range(65535, 4096));
    end
    return row;
  endfunction

  // Offer one request, wait for it to be taken, record its response
  task automatic issue_request(input stim_row_t row);
    resp_t want;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= row.op;
    request_bytes_i   <= row.bytes;
    payload_address_i <= row.addr;
    do @(posedge clk_i); while (in_stall_o);
    want = heap_response(row.op, row.bytes, row.addr);
    if (row.fixed_resp) want = row.resp;
    pending_responses.push_back(want);
    if (row.op == OP_ALLOC && want.status == ST_OK) live_addrs.push_back(want.addr);
  endtask

  // Receiver stall: random per phase, or one long hold-off on request
  initial begin : sink_ctrl
    int held;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        for (held = 1; held < HoldOffCycles; held++) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each response with the oldest prediction
  always @(posedge clk_i) begin : response_check
    resp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response, address %0d status %0d", $time,
                 result_address_o, status_o);
        fail_cnt++;
      end else begin
        want = pending_responses.pop_front();
        if (result_address_o !== want.addr) begin
          $display("%0t: result_address expected %0d, got %0d", $time, want.addr,
                   result_address_o);
          fail_cnt++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        phase;
    rst_ni            <= 1'b0;
    in_valid_i        <= 1'b0;
    opcode_i          <= OP_ALLOC;
    request_bytes_i   <= '0;
    payload_address_i <= '0;
    shadow_end  = '0;
    shadow_last = '0;
    foreach (shadow_hdr[g]) shadow_hdr[g] = '0;

    // op, bytes, address, typed, expected address, expected status
    add_row(OP_FREE,  0,     0,     1, 0,  ST_IGNORED);  // free of null
    add_row(OP_FREE,  0,     16,    1, 0,  ST_IGNORED);  // free on empty heap
    add_row(OP_ALLOC, 0,     0,     1, 16, ST_OK);       // smallest request
    add_row(OP_ALLOC, 8,     0,     1, 32, ST_OK);
    add_row(OP_ALLOC, 9,     0,     1, 48, ST_OK);       // two granules
    add_row(OP_ALLOC, 65535, 0,     1, 0,  ST_OOM);      // oversized
    add_row(OP_FREE,  0,     8,     1, 0,  ST_IGNORED);  // below first payload
    add_row(OP_FREE,  0,     17,    1, 0,  ST_IGNORED);  // misaligned
    add_row(OP_FREE,  65535, 65536, 1, 0,  ST_IGNORED);  // past heap end
    add_row(OP_FREE,  0,     64,    1, 0,  ST_IGNORED);  // inside a block
    add_row(OP_FREE,  0,     32,    1, 0,  ST_OK);
    add_row(OP_FREE,  0,     32,    1, 0,  ST_OK);       // double free
    add_row(OP_FREE,  0,     16,    1, 0,  ST_OK);
    add_row(OP_ALLOC, 24,    0,     0, 0,  ST_OK);       // merged pair, exact fit
    add_row(OP_ALLOC, 40000, 0,     0, 0,  ST_OK);       // large append
    add_row(OP_FREE,  0,     80,    1, 0,  ST_OK);
    add_row(OP_ALLOC, 100,   0,     0, 0,  ST_OK);       // split of the large block
    add_row(OP_FREE,  0,     96,    0, 0,  ST_OK);
    add_row(OP_ALLOC, 1000,  0,     0, 0,  ST_OK);
    add_row(OP_ALLOC, 65535, 65536, 0, 0,  ST_OK);
    add_row(OP_FREE,  0,     48,    1, 0,  ST_OK);
    add_row(OP_FREE,  0,     16,    1, 0,  ST_OK);
    add_row(OP_ALLOC, 40,    0,     0, 0,  ST_OK);       // whole block, no split
    add_row(OP_ALLOC, 20000, 0,     0, 0,  ST_OK);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) issue_request(directed_rows[i]);

    // Random phases: no idling with one long hold-off, sender gaps,
    // receiver stalls, then both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          gap_pct      = 0;
          stall_pct    = 0;
          hold_off_req = 1'b1;
        end
        1: begin
          gap_pct   = 46;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 46;
        end
        default: begin
          gap_pct   = 25;
          stall_pct = 25;
        end
      endcase
      repeat (RandomPerPhase) begin
        row = random_row();
        issue_request(row);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ilha_pkg.sv
src/ilha_ram.sv
src/implicit_list_heap_allocator.sv
src/ilha_checker.sv
verif/tb.sv
